FILE: hdl/cip_pkg.sv
// Package with beat types, multiplier status and sequencer states for the power core.
package cip_pkg;

  typedef struct packed {
    logic [63:0] base_value;
    logic [63:0] exponent;
  } arg_beat_t;

  typedef struct packed {
    logic [63:0] power_value;
    logic        overflow;
  } res_beat_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mul_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MULA,
    S_SQ,
    S_MULS,
    S_OUT
  } state_t;

  // Width of one multiplier digit.
  localparam int DIGIT = 16;

endpackage

FILE: hdl/checked_integer_power.sv
// Top level of the checked integer power core: sequencer around one shared multiplier.
//
//   channel   direction   handshake               beat
//   arg       in          arg_valid / arg_stall   arg_beat_t: base_value, exponent
//   res       out         res_valid / res_stall   res_beat_t: power_value, overflow
//
// One item is worked at a time; arg_stall is high from acceptance until its result is taken.
// An exponent bit needs at most two multiplies (the top bit one); trivial bases and
// large exponents go straight to the result. Reset is synchronous and returns the
// sequencer to idle. A stalled result holds in the output register until res_stall
// falls.
module checked_integer_power_core
  import cip_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      arg_valid,
  output logic      arg_stall,
  input  arg_beat_t arg,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res
);

  localparam int EW = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] WIDTH_W = WIDTH'(WIDTH);

  state_t           state, state_next;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [EW-1:0]    e;
  logic [WIDTH-1:0] power;
  logic             ovf;

  logic [WIDTH-1:0] base_in;
  logic [WIDTH-1:0] exp_in;
  logic             accept;
  logic             mul_start;
  logic [WIDTH-1:0] mul_a;
  logic [WIDTH-1:0] prod;
  mul_stat_t        mstat;

  assign base_in = arg.base_value[WIDTH-1:0];
  assign exp_in  = arg.exponent[WIDTH-1:0];
  assign accept  = arg_valid && (state == S_IDLE);
  assign mul_a   = (state == S_STEP) ? acc : sq;

  cip_mul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (sq),
    .prod (prod),
    .stat (mstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (arg_valid) begin
          if (base_in <= WIDTH'(1) || exp_in >= WIDTH_W) begin
            state_next = S_OUT;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (e == '0) begin
          state_next = S_OUT;
        end else if (e[0]) begin
          mul_start  = 1'b1;
          state_next = S_MULA;
        end else begin
          state_next = S_SQ;
        end
      end
      S_MULA: begin
        if (mstat.done) begin
          state_next = mstat.ovf ? S_OUT : S_SQ;
        end
      end
      S_SQ: begin
        if (e == '0) begin
          state_next = S_OUT;
        end else begin
          mul_start  = 1'b1;
          state_next = S_MULS;
        end
      end
      S_MULS: begin
        if (mstat.done) begin
          state_next = mstat.ovf ? S_OUT : S_STEP;
        end
      end
      S_OUT: begin
        if (!res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The exponent shifts right once per bit: after the optional multiply, or directly
  // when the low bit is clear.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          acc <= WIDTH'(1);
          sq  <= base_in;
          e   <= exp_in[EW-1:0];
          ovf <= (base_in > WIDTH'(1)) && (exp_in >= WIDTH_W);
          if (base_in <= WIDTH'(1)) begin
            power <= (exp_in == '0) ? WIDTH'(1) : base_in;
          end else if (exp_in >= WIDTH_W) begin
            power <= '0;
          end
        end
      end
      S_STEP: begin
        if (e == '0) begin
          power <= acc;
        end else if (!e[0]) begin
          e <= e >> 1;
        end
      end
      S_MULA: begin
        if (mstat.done) begin
          if (mstat.ovf) begin
            power <= '0;
            ovf   <= 1'b1;
          end else begin
            acc <= prod;
            e   <= e >> 1;
          end
        end
      end
      S_SQ: begin
        if (e == '0) begin
          power <= acc;
        end
      end
      S_MULS: begin
        if (mstat.done) begin
          if (mstat.ovf) begin
            power <= '0;
            ovf   <= 1'b1;
          end else begin
            sq <= prod;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign arg_stall       = (state != S_IDLE);
  assign res_valid       = (state == S_OUT);
  assign res.power_value = 64'(power);
  assign res.overflow    = ovf;

endmodule

FILE: hdl/cip_mul.sv
// Multi-cycle checked multiplier: one operand times one 16-bit digit of the other per cycle.
module cip_mul
  import cip_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] prod,
  output mul_stat_t        stat
);

  localparam int NDIG = (WIDTH + DIGIT - 1) / DIGIT;
  localparam int BW   = NDIG * DIGIT;
  localparam int PW   = WIDTH + BW;
  localparam int CW   = $clog2(NDIG + 1);

  logic [WIDTH-1:0]       a_r;
  logic [BW-1:0]          b_r;
  logic [PW-1:0]          acc;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   done;
  logic [DIGIT-1:0]       dig;
  logic [WIDTH+DIGIT-1:0] pp;

  assign dig = b_r[BW-1 -: DIGIT];
  assign pp  = {{DIGIT{1'b0}}, a_r} * {{WIDTH{1'b0}}, dig};

  // Digits are taken from the most significant end, so the sum shifts up each step.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << DIGIT) + PW'(pp);
      b_r <= b_r << DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NDIG);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod     = acc[WIDTH-1:0];
  assign stat.done = done;
  assign stat.ovf  = |acc[PW-1:WIDTH];

endmodule
